// ----- src/utmp_pkg.sv -----
// ----------------------------------------------------------------------------
// utmp_pkg: shared types and constants of the unit trade max profit block
// Holds word layouts, the cell entry type and the profit saturation helper.
// ----------------------------------------------------------------------------
package utmp_pkg;

  localparam int MAX_HOLD     = 32;
  localparam int PRICE_WIDTH  = 16;
  localparam int PRICE_FIELD  = 16;
  localparam int PROFIT_WIDTH = 48;
  localparam int FLAT_WIDTH   = 47;
  // Price bits that reach the datapath: the low PRICE_WIDTH bits of the field.
  localparam int PRICE_USED   = (PRICE_WIDTH < PRICE_FIELD) ? PRICE_WIDTH : PRICE_FIELD;

  typedef logic signed [PROFIT_WIDTH-1:0] profit_t;

  typedef struct packed {
    logic [PRICE_FIELD-1:0] price;
    logic                   last_day;
  } in_word_t;

  typedef struct packed {
    logic [FLAT_WIDTH-1:0] best_flat_profit;
    logic                  last;
  } out_word_t;

  // One holding count: best profit and whether it can be reached at all.
  typedef struct packed {
    logic    reach;
    profit_t profit;
  } entry_t;

  // Clamp a one-bit-wider sum back into the profit range.
  function automatic profit_t sat_profit(input logic signed [PROFIT_WIDTH:0] v);
    profit_t r;
    if (v[PROFIT_WIDTH] != v[PROFIT_WIDTH-1]) begin
      r = v[PROFIT_WIDTH] ? {1'b1, {(PROFIT_WIDTH-1){1'b0}}}
                          : {1'b0, {(PROFIT_WIDTH-1){1'b1}}};
    end else begin
      r = v[PROFIT_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

// ----- src/utmp_cell.sv -----
// ----------------------------------------------------------------------------
// utmp_cell: one holding count of the trading chain
// Picks the best of buy from the left, sell from the right and hold.
// ----------------------------------------------------------------------------
module utmp_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          home_i,    // set for holding count zero
  input  logic                          advance_i,
  input  logic                          restart_i,
  input  logic [utmp_pkg::PROFIT_WIDTH-1:0] price_i,
  input  utmp_pkg::entry_t              left_i,
  input  utmp_pkg::entry_t              right_i,
  output utmp_pkg::entry_t              entry_o,
  output utmp_pkg::entry_t              next_o
);

  utmp_pkg::entry_t  entry_q, entry_d;
  utmp_pkg::profit_t buy_val, sell_val, best;
  logic              have;

  assign buy_val  = utmp_pkg::sat_profit({left_i.profit[utmp_pkg::PROFIT_WIDTH-1],
                                          left_i.profit} -
                                         {1'b0, price_i});
  assign sell_val = utmp_pkg::sat_profit({right_i.profit[utmp_pkg::PROFIT_WIDTH-1],
                                          right_i.profit} +
                                         {1'b0, price_i});

  always_comb begin
    have = 1'b0;
    best = '0;
    if (left_i.reach) begin
      best = buy_val;
      have = 1'b1;
    end
    if (right_i.reach && (!have || sell_val > best)) begin
      best = sell_val;
    end
    if (right_i.reach) begin
      have = 1'b1;
    end
    if (entry_q.reach && (!have || entry_q.profit > best)) begin
      best = entry_q.profit;
    end
    if (entry_q.reach) begin
      have = 1'b1;
    end
  end

  assign next_o = '{reach: have, profit: have ? best : '0};

  always_comb begin
    entry_d = entry_q;
    if (advance_i) begin
      // Drop back to the start state after the final day.
      entry_d = restart_i ? '{reach: home_i, profit: '0} : next_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '{reach: home_i, profit: '0};
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

// ----- src/unit_trade_max_profit_dp.sv -----
// Best-profit tracker for trading one unit per day. Each accepted word carries
// a daily price and a last-day flag; the block answers every word with one
// word holding the best profit reachable so far while holding zero units, and
// an echo of the flag. A row of MAX_HOLD+1 cells, one per holding count, all
// update together in the cycle a word is accepted, so a word is taken every
// cycle unless input is stalled, and its answer appears in the next cycle from
// the output register. Each cell update is one saturating add or subtract per
// neighbor and a three-way max. Stall on the output only stops input when the
// output register is still full. Profits saturate to 48-bit signed range, and
// the reported flat profit is never negative. After a last-day word the cells
// return to the start state: only holding count zero reachable, all profits 0.
// ----------------------------------------------------------------------------
// unit_trade_max_profit_dp: top level of the trading profit chain
// Instantiates the cell row and holds the output register.
// ----------------------------------------------------------------------------
module unit_trade_max_profit_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  utmp_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output utmp_pkg::out_word_t out_word_o
);

  localparam int Cells = utmp_pkg::MAX_HOLD + 1;

  utmp_pkg::entry_t entry[Cells];
  utmp_pkg::entry_t next[Cells];
  utmp_pkg::entry_t left_in[Cells];
  utmp_pkg::entry_t right_in[Cells];

  logic [utmp_pkg::PROFIT_WIDTH-1:0] price_ext;
  logic                              advance;
  utmp_pkg::out_word_t               out_q, out_d;
  logic                              out_valid_q, out_valid_d;

  // Take a word whenever the output register is empty or drains this cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign advance    = in_valid_i && !in_stall_o;

  // Keep the low PRICE_WIDTH bits of the price, zero-extended.
  assign price_ext = {{(utmp_pkg::PROFIT_WIDTH - utmp_pkg::PRICE_USED){1'b0}},
                      in_word_i.price[utmp_pkg::PRICE_USED-1:0]};

  // Chain ends see an unreachable neighbor: no buy into count zero, no
  // sell from above MAX_HOLD.
  always_comb begin
    for (int c = 0; c < Cells; c++) begin
      left_in[c]  = (c == 0) ? '{reach: 1'b0, profit: '0} : entry[(c == 0) ? 0 : c - 1];
      right_in[c] = (c == Cells - 1) ? '{reach: 1'b0, profit: '0}
                                     : entry[(c == Cells - 1) ? c : c + 1];
    end
  end

  for (genvar g = 0; g < Cells; g++) begin : g_cell
    utmp_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .home_i    ((g == 0) ? 1'b1 : 1'b0),
      .advance_i (advance),
      .restart_i (in_word_i.last_day),
      .price_i   (price_ext),
      .left_i    (left_in[g]),
      .right_i   (right_in[g]),
      .entry_o   (entry[g]),
      .next_o    (next[g])
    );
  end

  // The answer comes from the updated count-zero entry, floored at zero.
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_d.best_flat_profit = (next[0].reach && !next[0].profit[utmp_pkg::PROFIT_WIDTH-1])
                             ? next[0].profit[utmp_pkg::FLAT_WIDTH-1:0] : '0;
      out_d.last             = in_word_i.last_day;
      out_valid_d            = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
